/* sv/spfm_pkg.sv */
// shared types and constants for the binary32 multiplier
`timescale 1ns / 1ps

package spfm_pkg;

    localparam int ExpWidth  = 8;
    localparam int FracWidth = 23;
    localparam int SigWidth  = FracWidth + 1;
    localparam int ProdWidth = 2 * SigWidth;
    localparam int WordWidth = 32;

    typedef enum logic [1:0] {
        STATUS_NORMAL    = 2'd0,
        STATUS_ZERO      = 2'd1,
        STATUS_OVERFLOW  = 2'd2,
        STATUS_UNDERFLOW = 2'd3
    } status_t;

endpackage

/* sv/spfm_mul24.sv */
// 24x24 significand multiplier, two register stages with stall enable
`timescale 1ns / 1ps

module spfm_mul24
    import spfm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic [SigWidth-1:0]  sig_a,
    input  logic [SigWidth-1:0]  sig_b,
    output logic [ProdWidth-1:0] prod
);

    logic [SigWidth-1:0]  a_reg;
    logic [SigWidth-1:0]  b_reg;
    logic [ProdWidth-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= sig_a;
            b_reg    <= sig_b;
            prod_reg <= ProdWidth'(a_reg) * ProdWidth'(b_reg);
        end
    end

    assign prod = prod_reg;

endmodule

/* sv/single_precision_float_multiplier.sv */
// truncating binary32 multiplier, top level with stream handshake
// an input transaction passes the stage 1 and stage 2 registers, then the output register
// throughput: one transaction per cycle while the output is not stalled; the multiplier pair sets the depth
// a stall holds every stage in place, nothing is lost or repeated
// reset: aresetn synchronous active low clears all stage valid bits
`timescale 1ns / 1ps

module single_precision_float_multiplier
    import spfm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // product [31:0], status [33:32], zeros above
);

    localparam int Stages = 3;

    logic [Stages-1:0] vld_reg;
    logic              en;

    // stage registers: stage 1 holds the exponent checks
    logic                 sign1_reg;
    logic [9:0]           exp1_reg;
    status_t              st1_reg;
    logic                 sign2_reg;
    logic [9:0]           exp2_reg;
    status_t              st2_reg;
    logic [WordWidth-1:0] prod_out_reg;
    status_t              st_out_reg;

    logic [WordWidth-1:0] op_a, op_b;
    logic [ExpWidth-1:0]  ea, eb;
    logic [9:0]           esum;
    status_t              st_in;
    logic [ProdWidth-1:0] sig_prod;
    logic                 carry;
    logic [ExpWidth-1:0]  biased;
    logic [FracWidth-1:0] frac;
    logic [WordWidth-1:0] word;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[Stages-1];

    assign op_a = s_tdata[31:0];
    assign op_b = s_tdata[63:32];
    assign ea   = op_a[30:23];
    assign eb   = op_b[30:23];
    // biased sum, in range 2..510 when both non-zero
    assign esum = {2'b00, ea} + {2'b00, eb};

    always_comb begin
        priority if (ea == '0 || eb == '0) begin
            st_in = STATUS_ZERO;
        end else if (esum > 10'd381) begin
            st_in = STATUS_OVERFLOW;
        end else if (esum < 10'd128) begin
            st_in = STATUS_UNDERFLOW;
        end else begin
            st_in = STATUS_NORMAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Stages-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sign1_reg <= op_a[31] ^ op_b[31];
            exp1_reg  <= esum - 10'd127;
            st1_reg   <= st_in;
            sign2_reg <= sign1_reg;
            exp2_reg  <= exp1_reg;
            st2_reg   <= st1_reg;
            prod_out_reg <= (st2_reg == STATUS_NORMAL) ? word : '0;
            st_out_reg   <= st2_reg;
        end
    end

    spfm_mul24 u_mul (
        .aclk  (aclk),
        .en    (en),
        .sig_a ({1'b1, op_a[FracWidth-1:0]}),
        .sig_b ({1'b1, op_b[FracWidth-1:0]}),
        .prod  (sig_prod)
    );

    // normalise by truncation on the carry bit
    assign carry  = sig_prod[ProdWidth-1];
    assign frac   = carry ? sig_prod[46:24] : sig_prod[45:23];
    assign biased = exp2_reg[7:0] + {7'd0, carry};
    assign word   = {sign2_reg, biased, frac};

    assign m_tdata = {6'd0, st_out_reg, prod_out_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_out_reg != STATUS_NORMAL |-> prod_out_reg == '0)
    else $error("special case product not zero");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

/* tb/single_precision_float_multiplier_test.sv */
// self-checking testbench for the truncating binary32 multiplier
`timescale 1ns / 1ps

module single_precision_float_multiplier_test;
    import spfm_pkg::*;

    typedef struct packed {
        logic [31:0] product;
        status_t     status;
    } mul_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          error_count = 0;
    longint      cycle_count = 0;
    mul_result_t expected_products[$];

    localparam longint CycleLimit = 400000;

    single_precision_float_multiplier dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic mul_result_t multiply_truncated(logic [31:0] a, logic [31:0] b);
        mul_result_t r;
        logic [7:0]  ea, eb;
        int          s;
        logic [47:0] prod;
        logic        carry;
        logic [22:0] frac;
        logic [7:0]  biased;
        ea = a[30:23];
        eb = b[30:23];
        r.product = '0;
        r.status = STATUS_NORMAL;
        if (ea == 0 || eb == 0) begin
            r.status = STATUS_ZERO;
            return r;
        end
        s = int'(ea) + int'(eb) - 254;
        if (s > 127) begin
            r.status = STATUS_OVERFLOW;
            return r;
        end
        if (s < -126) begin
            r.status = STATUS_UNDERFLOW;
            return r;
        end
        prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
        carry = prod[47];
        frac = carry ? prod[46:24] : prod[45:23];
        biased = 8'(s + 127 + int'(carry));
        r.product = {a[31] ^ b[31], biased, frac};
        return r;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("single_precision_float_multiplier test failed");
            $finish;
        end
    end

    // receiver stall and result check
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        mul_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_products.size() == 0) begin
                $error("unexpected result transaction %h", m_tdata);
                error_count++;
            end else begin
                exp_r = expected_products.pop_front();
                if (m_tdata[31:0] !== exp_r.product) begin
                    $error("product: expected %h actual %h", exp_r.product, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[33:32] !== exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status, m_tdata[33:32]);
                    error_count++;
                end
                if (m_tdata[39:34] !== 6'd0) begin
                    $error("padding: expected 0 actual %h", m_tdata[39:34]);
                    error_count++;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_operands(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_products.push_back(multiply_truncated(a, b));
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pack_float(logic sgn, logic [7:0] e, logic [22:0] f);
        return {sgn, e, f};
    endfunction

    task automatic test_directed();
        send_operands(32'h3F800000, 32'h3F800000);
        send_operands(32'h00000000, 32'h3F800000);
        send_operands(32'h3F800000, 32'h807FFFFF);
        send_operands(32'h00000000, 32'h00000000);
        send_operands(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_operands(32'h7F7FFFFF, 32'h7F7FFFFF);
        send_operands(32'h7F000000, 32'h3FFFFFFF);
        send_operands(32'h7F000000, 32'h3F800000);
        send_operands(32'h7F800000, 32'h3F800000);
        send_operands(32'h7F800000, 32'h00800000);
        send_operands(32'h7F000000, 32'h40000000);
        send_operands(32'h00800000, 32'h3F800000);
        send_operands(32'h00800000, 32'h3F000000);
        send_operands(32'h00800000, 32'h00800000);
        send_operands(32'h3FFFFFFF, 32'hBFFFFFFF);
        send_operands(32'hC0400000, 32'h40400000);
        send_operands(32'h7FFFFFFF, 32'h00FFFFFF);
        send_operands(32'h80800001, 32'h7F7FFFFF);
    endtask

    task automatic test_random(int count);
        logic [31:0] a, b;
        for (int i = 0; i < count; i++) begin
            a = $urandom;
            b = $urandom;
            // keep most exponents near the bias so the normal path dominates
            if ($urandom_range(9) < 7) begin
                a[30:23] = 8'($urandom_range(190, 64));
                b[30:23] = 8'($urandom_range(190, 64));
            end else if ($urandom_range(1)) begin
                a[30:23] = 8'($urandom_range(3) == 0 ? 0 : 255);
            end
            send_operands(a, b);
        end
    endtask

    task automatic set_pressure(int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        set_pressure(0, 0);
        test_random(220);
        set_pressure(70, 0);
        test_random(210);
        set_pressure(0, 70);
        test_random(210);
        set_pressure(25, 25);
        test_random(210);
        s_tvalid <= 1'b0;
        while (expected_products.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (error_count == 0) begin
            $display("single_precision_float_multiplier test passed");
        end else begin
            $display("single_precision_float_multiplier test failed");
        end
        $finish;
    end

endmodule
